// ----- rtl/tgdc_pkg.sv -----
// tgdc_pkg: shared types, constants and helpers for the goal distance cost block.
// No dependencies; imported by every module of the block.
package tgdc_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int ROOT_STEPS     = 33;   // 2-bit digits of a 66-bit radicand
    localparam int SUM_W          = 40;
    localparam int W_W            = 48;   // weighted value and power result
    localparam int QUEUE_DEPTH    = 4;

    localparam logic [47:0] CAP48 = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [2:0] {
        REG_ENABLE   = 3'd0,
        REG_EXPONENT = 3'd1,
        REG_WEIGHT   = 3'd2,
        REG_THRESH   = 3'd3,
        REG_GOAL_X   = 3'd4,
        REG_GOAL_Y   = 3'd5,
        REG_ROBOT_X  = 3'd6,
        REG_ROBOT_Y  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic               last_point;
    } t_point_req;

    typedef struct packed {
        logic [47:0] cost_add;
        logic        applied;
    } t_cost_res;

    typedef struct packed {
        logic               enable;
        logic [2:0]         cost_exponent;
        logic [15:0]        weight_q8;
        logic [31:0]        near_threshold;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
        logic signed [31:0] robot_x;
        logic signed [31:0] robot_y;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        t_point_req item;
    } t_queue_head;

    typedef struct packed {
        logic [7:0] count;   // points held in the running sum
        logic       busy;
    } t_back_status;

    typedef enum logic [3:0] {
        B_IDLE, B_SQX, B_SQY, B_SUM, B_ROOT, B_ACC, B_NMAG, B_THR,
        B_NEAR, B_DIV, B_WT, B_PINIT, B_POW, B_OUT
    } t_back_state;

    // |a - b| of two signed 32-bit values; always fits in 32 unsigned bits
    function automatic logic [31:0] abs_diff(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [32:0] d;
        d = {a[31], a} - {b[31], b};
        return d[32] ? 32'(-d) : d[31:0];
    endfunction

endpackage

// ----- rtl/tgdc_front.sv -----
// tgdc_front: accepts point requests and holds them in a short queue.
// Depends on tgdc_pkg.
module tgdc_front
    import tgdc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_point_req  i_in,
    output t_queue_head o_head,
    input  logic        i_pop,
    output logic [2:0]  o_level
);
    localparam int PtrW = $clog2(QUEUE_DEPTH);

    t_point_req r_mem [QUEUE_DEPTH];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [PtrW:0]   r_level;
    logic push, pop;

    assign o_in_stall = (r_level == (PtrW+1)'(QUEUE_DEPTH));
    assign push = i_in_valid && !o_in_stall;
    assign pop  = i_pop && (r_level != '0);
    assign o_head.valid = (r_level != '0);
    assign o_head.item  = r_mem[r_rp];
    assign o_level = 3'(r_level);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_level <= r_level + (PtrW+1)'(push) - (PtrW+1)'(pop);
        end
    end
endmodule

// ----- rtl/tgdc_back.sv -----
// tgdc_back: per-point distance, accumulation and end-of-trajectory cost sequencer.
// Depends on tgdc_pkg.
module tgdc_back
    import tgdc_pkg::*;
#(
    parameter int MaxPoints = MAX_POINTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    input  t_queue_head  i_head,
    output logic         o_pop,
    input  logic         i_out_stall,
    output logic         o_out_valid,
    output t_cost_res    o_out,
    output t_back_status o_status
);
    localparam int CntW = $clog2(MaxPoints + 1);

    t_back_state r_state, n_state;

    // datapath registers
    logic [31:0]      r_mx, r_my;
    logic [63:0]      r_sqa, r_sqb, r_thr2;
    logic [65:0]      r_rad;
    logic [36:0]      r_rem;
    logic [32:0]      r_root;
    logic [5:0]       r_step;
    logic             r_last, r_near_phase;
    logic [SUM_W-1:0] r_sum, r_dnum;
    logic [CntW-1:0]  r_count;
    logic [CntW:0]    r_drem;
    logic [W_W-1:0]   r_w, r_res, r_mplier;
    logic [95:0]      r_acc, r_mcand;
    logic [1:0]       r_pw;
    logic             r_applied;

    // shared 32x32 multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    always_comb begin
        case (r_state)
            B_SQY:   begin mul_a = r_my;                  mul_b = r_my; end
            B_THR:   begin mul_a = i_cfg.near_threshold;  mul_b = i_cfg.near_threshold; end
            default: begin mul_a = r_mx;                  mul_b = r_mx; end
        endcase
    end

    logic [64:0] sq_sum;
    assign sq_sum = {1'b0, r_sqa} + {1'b0, r_sqb};

    // square root digit step
    logic [36:0] rem_sh, trial;
    assign rem_sh = {r_rem[34:0], r_rad[65:64]};
    assign trial  = {2'b00, r_root, 2'b01};

    // division step
    logic [CntW:0] drem_sh;
    assign drem_sh = {r_drem[CntW-1:0], r_dnum[SUM_W-1]};

    logic [55:0] wprod;
    assign wprod = 56'(r_dnum) * 56'(i_cfg.weight_q8);

    logic [1:0] pw_init;
    always_comb begin
        case (i_cfg.cost_exponent)
            3'd0, 3'd1: pw_init = 2'd0;
            3'd2:       pw_init = 2'd1;
            3'd3:       pw_init = 2'd2;
            default:    pw_init = 2'd3;
        endcase
    end

    logic out_free;
    assign out_free = !o_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            B_IDLE: if (i_head.valid) begin
                o_pop   = 1'b1;
                n_state = B_SQX;
            end
            B_SQX:  n_state = B_SQY;
            B_SQY:  n_state = r_near_phase ? B_THR : B_SUM;
            B_SUM:  n_state = B_ROOT;
            B_ROOT: if (r_step == 6'(ROOT_STEPS - 1)) n_state = B_ACC;
            B_ACC:  n_state = r_last ? B_NMAG : B_IDLE;
            B_NMAG: n_state = B_SQX;
            B_THR:  n_state = B_NEAR;
            B_NEAR: n_state = (i_cfg.enable && (r_rad < {2'b00, r_thr2})) ? B_DIV : B_OUT;
            B_DIV:  if (r_step == 6'(SUM_W - 1)) n_state = B_WT;
            B_WT:   n_state = (pw_init == 2'd0) ? B_OUT : B_PINIT;
            B_PINIT: n_state = B_POW;
            B_POW:  if (r_step == 6'(W_W - 1)) begin
                if (r_acc[95:64] != '0 || r_pw == 2'd1) n_state = B_OUT;
                else                                    n_state = B_PINIT;
            end
            B_OUT:  if (out_free) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_count     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (r_state == B_OUT && out_free) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            if (r_state == B_ACC && r_count < CntW'(MaxPoints)) begin
                r_sum   <= r_sum + SUM_W'(r_root);
                r_count <= r_count + 1'b1;
            end
            if (r_state == B_OUT && out_free) begin
                r_sum       <= '0;
                r_count     <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_mx         <= abs_diff(i_head.item.point_x, i_cfg.goal_x);
                r_my         <= abs_diff(i_head.item.point_y, i_cfg.goal_y);
                r_last       <= i_head.item.last_point;
                r_near_phase <= 1'b0;
            end
            B_SQX: r_sqa <= mul_p;
            B_SQY: r_sqb <= mul_p;
            B_SUM: begin
                r_rad  <= {1'b0, sq_sum};
                r_rem  <= '0;
                r_root <= '0;
                r_step <= '0;
            end
            B_ROOT: begin
                r_rad  <= {r_rad[63:0], 2'b00};
                r_step <= r_step + 1'b1;
                if (rem_sh >= trial) begin
                    r_rem  <= rem_sh - trial;
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= rem_sh;
                    r_root <= {r_root[31:0], 1'b0};
                end
            end
            B_NMAG: begin
                r_mx         <= abs_diff(i_cfg.robot_x, i_cfg.goal_x);
                r_my         <= abs_diff(i_cfg.robot_y, i_cfg.goal_y);
                r_near_phase <= 1'b1;
            end
            B_THR: begin
                r_thr2 <= mul_p;
                r_rad  <= {1'b0, sq_sum};
            end
            B_NEAR: begin
                r_res     <= '0;
                r_applied <= 1'b0;
                r_dnum    <= r_sum;
                r_drem    <= '0;
                r_step    <= '0;
            end
            B_DIV: begin
                r_step <= r_step + 1'b1;
                if (r_count != '0 && drem_sh >= {1'b0, r_count}) begin
                    r_drem <= drem_sh - {1'b0, r_count};
                    r_dnum <= {r_dnum[SUM_W-2:0], 1'b1};
                end else begin
                    r_drem <= drem_sh;
                    r_dnum <= {r_dnum[SUM_W-2:0], 1'b0};
                end
            end
            B_WT: begin
                r_w       <= wprod[55:8];
                r_res     <= wprod[55:8];
                r_pw      <= pw_init;
                r_applied <= 1'b1;
            end
            B_PINIT: begin
                r_acc    <= '0;
                r_mcand  <= {48'd0, r_res};
                r_mplier <= r_w;
                r_step   <= '0;
            end
            B_POW: begin
                r_step   <= r_step + 1'b1;
                r_mcand  <= {r_mcand[94:0], 1'b0};
                r_mplier <= {1'b0, r_mplier[W_W-1:1]};
                if (r_mplier[0]) r_acc <= r_acc + r_mcand;
                if (r_step == 6'(W_W - 1)) begin
                    if ((r_acc + (r_mplier[0] ? r_mcand : 96'd0)) >> 64 != '0) begin
                        r_res <= CAP48;
                    end else begin
                        r_res <= 48'((r_acc + (r_mplier[0] ? r_mcand : 96'd0)) >> 16);
                    end
                    r_pw <= r_pw - 1'b1;
                end
            end
            B_OUT: if (out_free) begin
                o_out.cost_add <= r_res;
                o_out.applied  <= r_applied;
            end
            default: ;
        endcase
    end

    assign o_status.count = 8'(r_count);
    assign o_status.busy  = (r_state != B_IDLE);
endmodule

// ----- rtl/trajectory_goal_distance_cost.sv -----
// Trajectory goal distance cost: top level with configuration registers, queue and sequencer.
// Depends on tgdc_pkg, tgdc_front and tgdc_back.

// Each point request runs the pop, the shared 32x32 squaring unit, the radicand sum, a
// 33-step integer square root and the accumulate in the back end. A request with
// last_point adds the near test; when the term applies it also runs a 40-step mean
// division, the weight product and, for exponents 2 and above (5..7 act as 4), one
// bit-serial multiply per extra power. A closing point then waits in the result state
// until the output register is free.
// A four-entry queue takes requests while the back end works, and the result
// register lets the next trajectory proceed while a result still waits downstream.
// Configuration must be written only while the block is idle; the block does not enforce it.
module trajectory_goal_distance_cost
    import tgdc_pkg::*;
#(
    parameter int MaxPoints = MAX_POINTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_point_req  i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_cost_res   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    t_cfg         r_cfg;
    t_queue_head  head;
    t_back_status status;
    logic         pop;
    logic [2:0]   level;

    // configuration registers, reset to 5.0 weight and about 1.4 m threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable         <= 1'b1;
            r_cfg.cost_exponent  <= 3'd1;
            r_cfg.weight_q8      <= 16'd1280;
            r_cfg.near_threshold <= 32'd91750;
            r_cfg.goal_x         <= '0;
            r_cfg.goal_y         <= '0;
            r_cfg.robot_x        <= '0;
            r_cfg.robot_y        <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ENABLE:   r_cfg.enable         <= i_cfg_data[0];
                REG_EXPONENT: r_cfg.cost_exponent  <= i_cfg_data[2:0];
                REG_WEIGHT:   r_cfg.weight_q8      <= i_cfg_data[15:0];
                REG_THRESH:   r_cfg.near_threshold <= i_cfg_data;
                REG_GOAL_X:   r_cfg.goal_x         <= i_cfg_data;
                REG_GOAL_Y:   r_cfg.goal_y         <= i_cfg_data;
                REG_ROBOT_X:  r_cfg.robot_x        <= i_cfg_data;
                REG_ROBOT_Y:  r_cfg.robot_y        <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tgdc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_head     (head),
        .i_pop      (pop),
        .o_level    (level)
    );

    tgdc_back #(.MaxPoints(MaxPoints)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .o_status    (status)
    );

    // the running point count never passes the configured maximum
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.count <= 8'(MaxPoints)) else $error("point count above maximum");

    // queue occupancy stays within its depth
    a_level_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= 3'(QUEUE_DEPTH)) else $error("queue overflow");

    // a result that was not applied carries a zero term
    a_zero_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.applied) |-> (o_out.cost_add == '0))
        else $error("nonzero term without applied");

    // a pop only happens when the queue holds a request
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid) else $error("pop from empty queue");
endmodule

// ----- tb/tb_trajectory_goal_distance_cost.sv -----
// Testbench for trajectory_goal_distance_cost: streams trajectory points, predicts the
// mean goal distance cost of each trajectory and checks every cost result. Needs tgdc_pkg.
`timescale 1ns / 100ps

module tb_trajectory_goal_distance_cost;
    import tgdc_pkg::*;

    localparam int POINT_CAP   = 64;
    localparam int CYCLE_LIMIT = 4000000;
    localparam logic [63:0] SAT48 = 64'hFFFF_FFFF_FFFF;

    // Predicts cost terms from accepted points and checks emitted results in order.
    class cost_scoreboard;
        t_cfg        cfg;
        logic [39:0] dist_sum;
        logic [6:0]  npts;
        t_cost_res   pending[$];
        int          errors;
        int          n_checked;

        function new();
            cfg = '{enable: 1'b1, cost_exponent: 3'd1, weight_q8: 16'd1280,
                    near_threshold: 32'd91750, default: '0};
            dist_sum = '0;
            npts = '0;
            errors = 0;
            n_checked = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_ENABLE:   cfg.enable = val[0];
                REG_EXPONENT: cfg.cost_exponent = val[2:0];
                REG_WEIGHT:   cfg.weight_q8 = val[15:0];
                REG_THRESH:   cfg.near_threshold = val;
                REG_GOAL_X:   cfg.goal_x = val;
                REG_GOAL_Y:   cfg.goal_y = val;
                REG_ROBOT_X:  cfg.robot_x = val;
                REG_ROBOT_Y:  cfg.robot_y = val;
                default: ;
            endcase
        endfunction

        // exact squared distance, 65 bits
        function logic [64:0] dist_sq(logic signed [31:0] ax, logic signed [31:0] ay,
                                      logic signed [31:0] bx, logic signed [31:0] by);
            logic signed [33:0] dx, dy;
            logic [32:0] mx, my;
            dx = 34'(ax) - 34'(bx);
            dy = 34'(ay) - 34'(by);
            mx = dx < 0 ? 33'(-dx) : 33'(dx);
            my = dy < 0 ? 33'(-dy) : 33'(dy);
            return 65'(mx) * 65'(mx) + 65'(my) * 65'(my);
        endfunction

        function logic [63:0] int_root(logic [65:0] v);
            logic [67:0] rem, trial;
            logic [63:0] root;
            rem = '0;
            root = '0;
            for (int i = 32; i >= 0; i--) begin
                rem = (rem << 2) | 68'(v[2*i +: 2]);
                trial = (68'(root) << 2) | 68'd1;
                if (rem >= trial) begin
                    rem = rem - trial;
                    root = (root << 1) | 64'd1;
                end else begin
                    root = root << 1;
                end
            end
            return root;
        endfunction

        function logic [63:0] powered(logic [63:0] mean);
            logic [63:0] w, r;
            logic [127:0] prod;
            int p;
            w = (mean * 64'(cfg.weight_q8)) >> 8;
            r = w;
            p = cfg.cost_exponent;
            if (p < 1) p = 1;
            if (p > 4) p = 4;
            for (int k = 1; k < p; k++) begin
                prod = 128'(r) * 128'(w);
                if (prod[127:64] != 0) return SAT48;
                r = prod[79:16];
            end
            return r > SAT48 ? SAT48 : r;
        endfunction

        function void note_point(t_point_req req);
            t_cost_res res;
            logic [64:0] near_sq;
            logic [63:0] thr_sq;
            if (npts < POINT_CAP) begin
                dist_sum = dist_sum + 40'(int_root(66'(dist_sq(req.point_x, req.point_y,
                                                               cfg.goal_x, cfg.goal_y))));
                npts = npts + 7'd1;
            end
            if (!req.last_point) return;
            near_sq = dist_sq(cfg.robot_x, cfg.robot_y, cfg.goal_x, cfg.goal_y);
            thr_sq = 64'(cfg.near_threshold) * 64'(cfg.near_threshold);
            res = '0;
            if (cfg.enable && near_sq < 65'(thr_sq)) begin
                res.cost_add = 48'(powered(npts != 0 ? 64'(dist_sum) / 64'(npts) : 64'd0));
                res.applied = 1'b1;
            end
            pending.push_back(res);
            dist_sum = '0;
            npts = '0;
        endfunction

        function void check_result(t_cost_res got);
            t_cost_res exp_res;
            n_checked++;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result cost_add=%h applied=%b",
                         $time, got.cost_add, got.applied);
                errors++;
                return;
            end
            exp_res = pending.pop_front();
            if (got.cost_add !== exp_res.cost_add) begin
                $display("%0t: cost_add expected %h actual %h",
                         $time, exp_res.cost_add, got.cost_add);
                errors++;
            end
            if (got.applied !== exp_res.applied) begin
                $display("%0t: applied expected %b actual %b",
                         $time, exp_res.applied, got.applied);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    logic        in_stall;
    t_point_req  in_req;
    logic        out_valid;
    logic        out_stall;
    t_cost_res   out_res;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    cost_scoreboard sb;
    int  send_idle_pct;     // sender gap chance, percent
    int  recv_stall_pct;    // receiver stall chance, percent
    bit  hold_receiver;     // long receiver hold-off in progress
    int  n_points;
    int  cycle_count;

    trajectory_goal_distance_cost i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in       (in_req),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out      (out_res),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Receiver: sample handshake, then pick the next stall value.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall)
            sb.check_result(out_res);
        if (hold_receiver)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("trajectory_goal_distance_cost: mismatch");
            $finish;
        end
    end

    // One write strobe, then a quiet gap with cfg_we low so back-to-back writes never collide.
    task automatic write_cfg(t_reg_idx idx, logic [31:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge i_clk);
    endtask

    // Offer one request and hold it until accepted; random gap before it.
    // Valid stays high after acceptance; the next gap or drain() drops it.
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic last);
        t_point_req req;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        req.point_x = px;
        req.point_y = py;
        req.last_point = last;
        in_valid <= 1'b1;
        in_req   <= req;
        do @(posedge i_clk); while (in_stall);
        sb.note_point(req);
        n_points++;
    endtask

    // Wait for all results, then let a closing/backend pass drain before config writes.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'(int'($urandom_range(0, 2 * 65536 * 8)) - 65536 * 8);
            default: return 32'(int'($urandom_range(0, 2 * 65536 * 2048)) - 65536 * 2048);
        endcase
    endfunction

    // Mostly short well-formed trajectories; some long ones exceed the point cap.
    task automatic random_trajectories(int npoints, int mode);
        int len;
        int sent;
        sent = 0;
        while (sent < npoints) begin
            len = ($urandom_range(19) == 0) ? $urandom_range(60, 80) : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                send_point(rand_coord(mode), rand_coord(mode), k == len - 1);
                sent++;
            end
        end
    endtask

    task automatic random_config(int mode);
        write_cfg(REG_ENABLE, 32'($urandom_range(9) != 0));
        write_cfg(REG_EXPONENT, $urandom_range(7));
        write_cfg(REG_WEIGHT, $urandom_range(1) ? $urandom_range(2048) : $urandom_range(65535));
        write_cfg(REG_GOAL_X, rand_coord(mode));
        write_cfg(REG_GOAL_Y, rand_coord(mode));
        write_cfg(REG_ROBOT_X, sb.cfg.goal_x + 32'(int'($urandom_range(0, 131072)) - 65536));
        write_cfg(REG_ROBOT_Y, sb.cfg.goal_y + 32'(int'($urandom_range(0, 131072)) - 65536));
        // mostly near, sometimes far or zero threshold
        case ($urandom_range(5))
            0: write_cfg(REG_THRESH, 32'd0);
            1: write_cfg(REG_THRESH, $urandom_range(65536));
            2: write_cfg(REG_THRESH, 32'hFFFF_FFFF);
            default: write_cfg(REG_THRESH, 32'd200000);
        endcase
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_req = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = REG_ENABLE;
        cfg_data = '0;
        hold_receiver = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        n_points = 0;
        cycle_count = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset config, then extremes of coordinates.
        send_point(32'd65536, 32'd0, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        drain();
        // far extreme goal, max weight, each exponent incl. out of range 0 and 7
        write_cfg(REG_GOAL_X, 32'h8000_0000);
        write_cfg(REG_GOAL_Y, 32'h7FFF_FFFF);
        write_cfg(REG_ROBOT_X, 32'h8000_0000);
        write_cfg(REG_ROBOT_Y, 32'h7FFF_FFFF);
        write_cfg(REG_WEIGHT, 32'h0000_FFFF);
        write_cfg(REG_THRESH, 32'hFFFF_FFFF);
        for (int e = 0; e < 8; e++) begin
            write_cfg(REG_EXPONENT, e);
            send_point(32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
            send_point(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
            drain();
        end
        // robot exactly at threshold distance is not near; disabled yields zero
        write_cfg(REG_WEIGHT, 32'd0);
        send_point(32'd0, 32'd0, 1'b1);
        drain();
        write_cfg(REG_WEIGHT, 32'd256);
        write_cfg(REG_ROBOT_X, 32'h8001_0000);
        write_cfg(REG_THRESH, 32'h0001_0000);
        send_point(32'd0, 32'd0, 1'b1);
        drain();
        write_cfg(REG_ENABLE, 32'd0);
        write_cfg(REG_ROBOT_X, 32'h8000_0000);
        send_point(32'd5, 32'd7, 1'b1);
        drain();
        write_cfg(REG_ENABLE, 32'd1);
        write_cfg(REG_EXPONENT, 32'd2);
        // point cap: 70 points, the extra ones must be dropped
        for (int k = 0; k < 70; k++)
            send_point(32'h8000_0000 + k * 32'h1_0000, 32'h7FFF_FFFF, k == 69);
        drain();

        // Random phases with varied idling.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            random_config(ph % 3);
            if (ph == 2) begin
                // long receiver hold-off while points keep coming
                fork
                    begin
                        hold_receiver = 1'b1;
                        repeat (3000) @(posedge i_clk);
                        hold_receiver = 1'b0;
                    end
                    random_trajectories(60, ph % 3);
                join
            end
            random_trajectories(200, ph % 3);
            // sender pause until every result is back
            drain();
        end

        $display("covered %0d points and %0d cost results over directed and random settings",
                 n_points, sb.n_checked);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("trajectory_goal_distance_cost: match");
        else
            $display("trajectory_goal_distance_cost: mismatch");
        $finish;
    end
endmodule
